// ===== rtl/brl_pkg.sv =====
// brl_pkg: shared types and the per-octant stepping rules of the line rasterizer
// depends on nothing; used by brl_step_unit and bresenham_line_rasterizer_core
package brl_pkg;

	// tie test applied to the error after the minor update
	typedef enum logic [1:0] {
		TIE_LT,
		TIE_LE,
		TIE_GT,
		TIE_GE
	} tie_t;

	typedef logic [3:0] octant_t;

	localparam octant_t OCT_1 = 4'd1;
	localparam octant_t OCT_2 = 4'd2;
	localparam octant_t OCT_3 = 4'd3;
	localparam octant_t OCT_4 = 4'd4;
	localparam octant_t OCT_5 = 4'd5;
	localparam octant_t OCT_6 = 4'd6;
	localparam octant_t OCT_7 = 4'd7;
	localparam octant_t OCT_8 = 4'd8;

	// stepping rule of one octant
	typedef struct packed {
		logic y_major;   // major axis is y
		logic major_dec; // major coordinate steps down
		logic add_minor; // error adds twice the minor delta
		logic minor_dec; // minor coordinate steps down
		tie_t tie;
	} oct_rule_t;

	function automatic oct_rule_t oct_rule(input octant_t oct);
		oct_rule_t r;
		case (oct)
			OCT_1: r = '{y_major: 1'b0, major_dec: 1'b0, add_minor: 1'b0, minor_dec: 1'b0,
				tie: TIE_LT};
			OCT_2: r = '{y_major: 1'b1, major_dec: 1'b0, add_minor: 1'b0, minor_dec: 1'b0,
				tie: TIE_LT};
			OCT_3: r = '{y_major: 1'b1, major_dec: 1'b0, add_minor: 1'b1, minor_dec: 1'b1,
				tie: TIE_LE};
			OCT_4: r = '{y_major: 1'b0, major_dec: 1'b1, add_minor: 1'b1, minor_dec: 1'b0,
				tie: TIE_GE};
			OCT_5: r = '{y_major: 1'b0, major_dec: 1'b1, add_minor: 1'b0, minor_dec: 1'b1,
				tie: TIE_GE};
			OCT_6: r = '{y_major: 1'b1, major_dec: 1'b1, add_minor: 1'b0, minor_dec: 1'b1,
				tie: TIE_GE};
			OCT_7: r = '{y_major: 1'b1, major_dec: 1'b1, add_minor: 1'b1, minor_dec: 1'b0,
				tie: TIE_GT};
			OCT_8: r = '{y_major: 1'b0, major_dec: 1'b0, add_minor: 1'b1, minor_dec: 1'b1,
				tie: TIE_LT};
			default: r = '{y_major: 1'b0, major_dec: 1'b0, add_minor: 1'b0, minor_dec: 1'b0,
				tie: TIE_LT};
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/brl_step_unit.sv =====
// brl_step_unit: one bresenham step (major advance, error update, tie test, minor advance)
// depends on brl_pkg for the octant rule type
module brl_step_unit
	import brl_pkg::*;
#(
	parameter int COORD_BITS = 6
) (
	input  oct_rule_t                     rule,
	input  logic [COORD_BITS-1:0]         major,
	input  logic [COORD_BITS-1:0]         minor,
	input  logic signed [COORD_BITS+2:0]  err,
	input  logic signed [COORD_BITS+2:0]  dmin_term,
	input  logic signed [COORD_BITS+2:0]  dmaj2,
	output logic [COORD_BITS-1:0]         major_next,
	output logic [COORD_BITS-1:0]         minor_next,
	output logic signed [COORD_BITS+2:0]  err_next
);

	localparam int EW = COORD_BITS + 3;

	logic signed [EW-1:0] err_mid;
	logic                 neg;
	logic                 zero;
	logic                 hit;

	always_comb begin
		err_mid = err + dmin_term;
		neg     = err_mid[EW-1];
		zero    = (err_mid == '0);
		case (rule.tie)
			TIE_LT: hit = neg;
			TIE_LE: hit = neg | zero;
			TIE_GT: hit = !neg && !zero;
			TIE_GE: hit = !neg;
			default: hit = 1'b0;
		endcase
		err_next   = hit ? err_mid + dmaj2 : err_mid;
		major_next = rule.major_dec ? major - 1'b1 : major + 1'b1;
		if (hit) begin
			minor_next = rule.minor_dec ? minor - 1'b1 : minor + 1'b1;
		end else begin
			minor_next = minor;
		end
	end

endmodule

// ===== rtl/bresenham_line_rasterizer_core.sv =====
// bresenham_line_rasterizer_core: all-octant line rasterizer, one pixel per cycle unless stalled
// depends on brl_pkg and brl_step_unit
//
//  channel | signals                                   | dir | notes
//  --------+-------------------------------------------+-----+------------------------------
//  in      | in_valid in_ready start_x start_y end_x end_y | in  | one transaction = one line
//  out     | out_valid out_ready pixel_x pixel_y last_pixel | out | one transaction = one pixel
//
// a line gives max(|dx|,|dy|)+1 pixels; the block first captures the line, then sets up
//   deltas and octant in ST_SETUP, then, without stalls, gives one pixel per cycle from
//   the shared step unit
// in_ready is high only while idle; the next line can be taken the cycle after the
//   last pixel's transaction
// out_ready low simply holds the current pixel; the step unit advances only on a
//   completed out transaction
// arst_n clears the sequencer to idle; datapath registers are not reset
module bresenham_line_rasterizer_core
	import brl_pkg::*;
#(
	parameter int COORD_BITS = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_BITS-1:0]  start_x,
	input  logic signed [COORD_BITS-1:0]  start_y,
	input  logic signed [COORD_BITS-1:0]  end_x,
	input  logic signed [COORD_BITS-1:0]  end_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_BITS-1:0]  pixel_x,
	output logic signed [COORD_BITS-1:0]  pixel_y,
	output logic                          last_pixel
);

	localparam int CW = COORD_BITS;
	localparam int DW = COORD_BITS + 1; // signed delta
	localparam int EW = COORD_BITS + 3; // signed error term

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_EMIT
	} state_t;

	state_t state_q;

	// captured line endpoints
	logic [CW-1:0] sx_q, sy_q, ex_q, ey_q;

	// stepping state
	oct_rule_t            rule_q;
	logic [CW-1:0]        major_q;
	logic [CW-1:0]        minor_q;
	logic [CW-1:0]        major_end_q;
	logic signed [EW-1:0] err_q;
	logic signed [EW-1:0] dmin_term_q;
	logic signed [EW-1:0] dmaj2_q;

	logic in_xfer;
	logic out_xfer;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign in_xfer   = in_valid & in_ready;
	assign out_xfer  = out_valid & out_ready;

	// output pixel: map major/minor back onto x/y
	assign pixel_x    = rule_q.y_major ? minor_q : major_q;
	assign pixel_y    = rule_q.y_major ? major_q : minor_q;
	assign last_pixel = (major_q == major_end_q);

	// ---------------------------------------------------------------
	// setup: deltas, octant, initial error
	// ---------------------------------------------------------------
	logic signed [DW-1:0] dx, dy;
	logic [DW-1:0]        adx, ady;
	logic                 x_major;
	logic                 dx_pos, dy_pos;
	octant_t              octant;
	oct_rule_t            setup_rule;
	logic signed [DW-1:0] dmaj, dmin;
	logic signed [EW-1:0] dmaj2, dmin2;

	always_comb begin
		dx      = $signed({ex_q[CW-1], ex_q}) - $signed({sx_q[CW-1], sx_q});
		dy      = $signed({ey_q[CW-1], ey_q}) - $signed({sy_q[CW-1], sy_q});
		adx     = dx[DW-1] ? -dx : dx;
		ady     = dy[DW-1] ? -dy : dy;
		x_major = (adx >= ady); // diagonals stay x-major
		dx_pos  = !dx[DW-1] && (dx != '0);
		dy_pos  = !dy[DW-1] && (dy != '0);
		if (dx_pos) begin
			if (dy_pos) octant = x_major ? OCT_1 : OCT_2;
			else        octant = x_major ? OCT_8 : OCT_7;
		end else begin
			if (dy_pos) octant = x_major ? OCT_4 : OCT_3;
			else        octant = x_major ? OCT_5 : OCT_6;
		end
		setup_rule = oct_rule(octant);
		dmaj  = setup_rule.y_major ? dy : dx;
		dmin  = setup_rule.y_major ? dx : dy;
		dmaj2 = {dmaj[DW-1], dmaj, 1'b0};
		dmin2 = {dmin[DW-1], dmin, 1'b0};
	end

	// ---------------------------------------------------------------
	// shared step unit
	// ---------------------------------------------------------------
	logic [CW-1:0]        major_next;
	logic [CW-1:0]        minor_next;
	logic signed [EW-1:0] err_next;

	brl_step_unit #(
		.COORD_BITS (COORD_BITS)
	) u_step (
		.rule       (rule_q),
		.major      (major_q),
		.minor      (minor_q),
		.err        (err_q),
		.dmin_term  (dmin_term_q),
		.dmaj2      (dmaj2_q),
		.major_next (major_next),
		.minor_next (minor_next),
		.err_next   (err_next)
	);

	// ---------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_xfer && last_pixel) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sx_q <= start_x;
			sy_q <= start_y;
			ex_q <= end_x;
			ey_q <= end_y;
		end
		if (state_q == ST_SETUP) begin
			rule_q      <= setup_rule;
			major_q     <= setup_rule.y_major ? sy_q : sx_q;
			minor_q     <= setup_rule.y_major ? sx_q : sy_q;
			major_end_q <= setup_rule.y_major ? ey_q : ex_q;
			err_q       <= {dmaj[DW-1], dmaj[DW-1], dmaj};
			dmin_term_q <= setup_rule.add_minor ? dmin2 : -dmin2;
			dmaj2_q     <= dmaj2;
		end else if (out_xfer && !last_pixel) begin
			major_q <= major_next;
			minor_q <= minor_next;
			err_q   <= err_next;
		end
	end

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("in_ready high right after a line transaction");

	a_never_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("taking a line while pixels are pending");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && last_pixel) |=> (in_ready && !out_valid))
		else $error("block not idle after last pixel");

	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && !last_pixel) |=> out_valid)
		else $error("gap between pixels of one line");

	a_setup_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> ##1 out_valid)
		else $error("first pixel not presented two cycles after line transaction");

endmodule
